@@ sv/aps_pkg.sv @@
// shared constants for the anemometer pulse speed block
// register map, reset values and field widths; no dependencies
package aps_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int DEBOUNCE_W  = 10;
    localparam int SPEED_K_W   = 16;
    localparam int CODE_W      = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [SPEED_K_W-1:0]  SPEED_K_RST  = 16'd2988;

    // register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_SPEED_K  = 1'b1;

endpackage

@@ sv/aps_if.sv @@
// valid/ready channel interfaces for tick input and speed output
// depends on aps_pkg for field widths
interface aps_in_if;
    logic valid;
    logic ready;
    logic edge_seen;

    modport source (output valid, output edge_seen, input ready);
    modport sink   (input valid, input edge_seen, output ready);
endinterface

interface aps_out_if;
    logic                        valid;
    logic                        ready;
    logic [aps_pkg::CODE_W-1:0]  speed_code;
    logic                        new_reading;

    modport source (output valid, output speed_code, output new_reading, input ready);
    modport sink   (input valid, input speed_code, input new_reading, output ready);
endinterface

@@ sv/anemometer_pulse_speed_core.sv @@
// anemometer pulse period wind speed core, single module
// depends on aps_pkg and the channel interfaces in aps_if.sv
//
// i_in transfers one millisecond tick with edge_seen, set when the anemometer
//   gave a falling edge during that tick; every tick gives exactly one o_out
//   transfer with the held speed in quarter km/h and new_reading, set when that
//   tick closed an interval. edges closer than debounce_ms to the last accepted
//   edge are dropped; accepted edges alternate between opening and closing
// flow: a tick that closes a nonzero interval runs the shared compare/subtract
//   unit (saturation check, then 8 quotient bits) and its result then passes
//   through the result slot and the output register to o_out; a saturated speed
//   stops after the check; any other tick goes straight to the result slot.
//   i_in.ready is low while the divider runs and while the result slot is full,
//   so a new tick waits until the last one has left the divider and result slot
// reset: i_rst_n (synchronous) clears time, edge history, held speed and both
//   result stages and restores debounce_ms=50 and speed_constant=2988
// stall: while o_out.ready is low the output holds and one more result waits
//   in the result slot; after that i_in.ready stays low
// configuration: APB writes at 0 (debounce_ms) and 4 (speed_constant), idle only
module anemometer_pulse_speed_core #(
    parameter int TIME_BITS = aps_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    aps_in_if.sink                          i_in,
    aps_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [aps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [aps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    // numerator 2K+I fits TIME_BITS+2; divisor 2I scaled by 256 needs TIME_BITS+9
    localparam int NW = TIME_BITS + 2;
    localparam int DW = TIME_BITS + 9;
    localparam int CW = aps_pkg::CODE_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    localparam logic [3:0] CNT_TOP = 4'd8;

    // configuration registers
    logic [aps_pkg::DEBOUNCE_W-1:0] r_deb;
    logic [aps_pkg::SPEED_K_W-1:0]  r_k;

    // edge timing state
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] r_start;
    logic                 r_open;
    logic [CW-1:0]        r_held;

    // divider
    logic                 r_state;
    logic [NW-1:0]        r_rem;
    logic [DW-1:0]        r_dsh;
    logic [CW-1:0]        r_quo;
    logic [3:0]           r_cnt;

    // result slot and output register
    logic                 r_res_v;
    logic [CW-1:0]        r_res_code;
    logic                 r_res_new;
    logic                 r_out_v;
    logic [CW-1:0]        r_out_code;
    logic                 r_out_new;

    logic                 acc;
    logic                 cfg_wr;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] interval;
    logic                 edge_ok;
    logic                 div_ge;
    logic [NW-1:0]        div_diff;
    logic [CW-1:0]        n_quo;
    logic                 out_load;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == aps_pkg::REG_SPEED_K)
                  ? aps_pkg::APB_DATA_W'(r_k)
                  : aps_pkg::APB_DATA_W'(r_deb);

    assign i_in.ready = (r_state == S_IDLE) && !r_res_v;
    assign acc        = i_in.valid && i_in.ready;

    // debounce distance and interval, both modulo 2^TIME_BITS
    assign since    = r_time - r_last;
    assign interval = r_time - r_start;
    assign edge_ok  = i_in.edge_seen && (since >= TIME_BITS'(r_deb));

    // shared compare/subtract step of the restoring divider
    assign div_ge   = DW'(r_rem) >= r_dsh;
    assign div_diff = r_rem - r_dsh[NW-1:0];
    assign n_quo    = {r_quo[CW-2:0], div_ge};

    assign out_load = r_res_v && (!r_out_v || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= aps_pkg::DEBOUNCE_RST;
            r_k   <= aps_pkg::SPEED_K_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == aps_pkg::REG_SPEED_K) begin
                r_k <= pwdata[aps_pkg::SPEED_K_W-1:0];
            end else begin
                r_deb <= pwdata[aps_pkg::DEBOUNCE_W-1:0];
            end
        end
    end

    // tick handling and divider sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_last  <= '0;
            r_start <= '0;
            r_open  <= 1'b0;
            r_held  <= '0;
            r_state <= S_IDLE;
            r_res_v <= 1'b0;
        end else begin
            if (out_load) begin
                r_res_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_time     <= r_time + 1'b1;
                        r_res_v    <= 1'b1;
                        r_res_code <= r_held;
                        r_res_new  <= 1'b0;
                        if (edge_ok) begin
                            r_last <= r_time;
                            if (!r_open) begin
                                r_start <= r_time;
                                r_open  <= 1'b1;
                            end else begin
                                r_open <= 1'b0;
                                // zero interval only on an exact wrap: no update
                                if (interval != '0) begin
                                    r_res_v <= 1'b0;
                                    r_rem   <= NW'({r_k, 1'b0}) + NW'(interval);
                                    r_dsh   <= {interval, 9'b0};
                                    r_quo   <= '0;
                                    r_cnt   <= CNT_TOP;
                                    r_state <= S_DIV;
                                end
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_TOP) begin
                        // quotient of 256 or more saturates
                        if (div_ge) begin
                            r_held     <= '1;
                            r_res_v    <= 1'b1;
                            r_res_code <= '1;
                            r_res_new  <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_dsh <= r_dsh >> 1;
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end else begin
                        if (div_ge) begin
                            r_rem <= div_diff;
                        end
                        r_quo <= n_quo;
                        r_dsh <= r_dsh >> 1;
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == 4'd0) begin
                            r_held     <= n_quo;
                            r_res_v    <= 1'b1;
                            r_res_code <= n_quo;
                            r_res_new  <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v    <= 1'b1;
            r_out_code <= r_res_code;
            r_out_new  <= r_res_new;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.speed_code  = r_out_code;
    assign o_out.new_reading = r_out_new;

endmodule

@@ sv/aps_checker.sv @@
// port-level checks for anemometer_pulse_speed_core, attached by bind
// depends on aps_pkg for the code width
module aps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [aps_pkg::CODE_W-1:0] i_out_code,
    input logic                       i_out_new,
    input logic                       i_pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code)
                                        && $stable(i_out_new))
        else $error("stalled output changed");

    // one tick in flight: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // nothing leaves in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // no zero-wait config port ever stalls
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind anemometer_pulse_speed_core aps_checker u_aps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_code  (o_out.speed_code),
    .i_out_new   (o_out.new_reading),
    .i_pready    (pready)
);

@@ sim/anemometer_pulse_speed_core_tb.sv @@
// self-checking testbench for anemometer_pulse_speed_core: tick stimulus, apb setup,
// and a scoreboard that predicts each speed transfer; needs aps_pkg, aps_if.sv and the core

class speed_scoreboard #(int TW = 16);
    typedef struct packed {
        logic [aps_pkg::CODE_W-1:0] code;
        logic                       fresh;
    } reading_t;

    bit [TW-1:0]                   tick_now;
    bit [TW-1:0]                   last_edge_at;
    bit [TW-1:0]                   open_at;
    bit                            interval_open;
    bit [aps_pkg::CODE_W-1:0]      held_code;
    bit [aps_pkg::DEBOUNCE_W-1:0]  debounce_ms;
    bit [aps_pkg::SPEED_K_W-1:0]   speed_k;
    reading_t                      readings_due[$];
    int                            errors;

    function new();
        tick_now      = '0;
        last_edge_at  = '0;
        open_at       = '0;
        interval_open = 1'b0;
        held_code     = '0;
        debounce_ms   = aps_pkg::DEBOUNCE_RST;
        speed_k       = aps_pkg::SPEED_K_RST;
        errors        = 0;
    endfunction

    function int pending();
        return readings_due.size();
    endfunction

    // one accepted tick, one reading expected
    function void note_tick(bit edge_flag);
        bit [TW-1:0]     since;
        bit [TW-1:0]     span;
        longint unsigned quot;
        reading_t        due;
        due.fresh = 1'b0;
        if (edge_flag) begin
            since = tick_now - last_edge_at;
            if (since >= debounce_ms) begin
                last_edge_at = tick_now;
                if (!interval_open) begin
                    open_at       = tick_now;
                    interval_open = 1'b1;
                end else begin
                    span          = tick_now - open_at;
                    interval_open = 1'b0;
                    if (span != '0) begin
                        // round to nearest quarter, ties up, then clip
                        quot = (2 * longint'(speed_k) + longint'(span))
                             / (2 * longint'(span));
                        held_code = (quot > 255) ? 8'd255 : quot[7:0];
                        due.fresh = 1'b1;
                    end
                end
            end
        end
        tick_now = tick_now + 1'b1;
        due.code = held_code;
        readings_due.push_back(due);
    endfunction

    function void check_reading(logic [aps_pkg::CODE_W-1:0] code, logic fresh);
        reading_t due;
        if (readings_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected speed transfer: code %0d new_reading %b", code, fresh);
            return;
        end
        due = readings_due.pop_front();
        if (code !== due.code || fresh !== due.fresh) begin
            errors++;
            if (errors <= 10)
                $display("speed mismatch: expected code %0d new_reading %b, %s %0d %s %b",
                         due.code, due.fresh, "got code", code, "new_reading", fresh);
        end
    endfunction
endclass

module anemometer_pulse_speed_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // smallest supported tick counter
    localparam int TICK_BITS  = 16;
    localparam int IDLE_LIMIT = 4000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [aps_pkg::APB_ADDR_W-1:0]  paddr;
    logic [aps_pkg::APB_DATA_W-1:0]  pwdata;
    logic [aps_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    aps_in_if  tick_if ();
    aps_out_if speed_if ();

    speed_scoreboard #(TICK_BITS) sb;

    bit calm_in;        // sender offers back to back while set
    int results_seen;   // accepted speed transfers
    int hold_left;      // remaining cycles of the long receiver hold-off
    bit hold_done;
    int quiet_cycles;   // watchdog: cycles with no transfer on either side

    anemometer_pulse_speed_core #(.TIME_BITS(TICK_BITS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (speed_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // offer one tick, with a random gap in front unless the sender is calm
    task automatic send_tick(input bit edge_flag);
        if (!calm_in) begin
            while ($urandom_range(99) < 27) begin
                tick_if.valid     <= 1'b0;
                tick_if.edge_seen <= 1'($urandom);
                @(posedge i_clk);
            end
        end
        tick_if.valid     <= 1'b1;
        tick_if.edge_seen <= edge_flag;
        do @(posedge i_clk); while (!tick_if.ready);
        sb.note_tick(edge_flag);
    endtask

    task automatic run_ticks(input int count, input int edge_pct);
        repeat (count) send_tick($urandom_range(99) < edge_pct);
    endtask

    // apb write: setup phase, access phase, then the bus returns to idle
    task automatic write_reg(input logic idx, input logic [aps_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == aps_pkg::REG_DEBOUNCE)
            sb.debounce_ms = value[aps_pkg::DEBOUNCE_W-1:0];
        else
            sb.speed_k = value[aps_pkg::SPEED_K_W-1:0];
        @(posedge i_clk);
    endtask

    // drain the block, then change both registers while it is idle
    task automatic set_config(input int deb, input int k);
        tick_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        write_reg(aps_pkg::REG_DEBOUNCE, deb);
        write_reg(aps_pkg::REG_SPEED_K, k);
    endtask

    // receiver: check every transfer, stall at random, one long hold-off,
    // and a calm window where it never stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            speed_if.ready <= 1'b0;
        end else begin
            if (speed_if.valid && speed_if.ready) begin
                sb.check_reading(speed_if.speed_code, speed_if.new_reading);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                speed_if.ready <= 1'b0;
            end else if (results_seen == 400 && !hold_done) begin
                // sender keeps offering, so the result slot fills and input stalls
                hold_done = 1'b1;
                hold_left = 300;
                speed_if.ready <= 1'b0;
            end else if (results_seen >= 180 && results_seen < 300) begin
                speed_if.ready <= 1'b1;
            end else begin
                speed_if.ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    // watchdog on transfers in either direction
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((tick_if.valid && tick_if.ready) || (speed_if.valid && speed_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        sb                = new();
        calm_in           = 1'b0;
        results_seen      = 0;
        hold_left         = 0;
        hold_done         = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        tick_if.valid     = 1'b0;
        tick_if.edge_seen = 1'b0;
        speed_if.ready    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: edges right after reset fall inside the debounce window
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);

        // zero debounce, largest constant: one-tick intervals saturate
        set_config(0, 65535);
        repeat (4) send_tick(1'b1);

        // zero constant rounds down to a zero code
        set_config(0, 0);
        send_tick(1'b1);
        send_tick(1'b1);

        // smallest constant, two-tick interval rounds up to one
        set_config(0, 1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // exact half quarter ties upward
        set_config(0, 3);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // random phases over several settings
        set_config(0, $urandom_range(65535, 1));
        run_ticks(150, 30);

        calm_in = 1'b1;
        set_config($urandom_range(20, 1), $urandom_range(5000, 300));
        run_ticks(150, 20);
        calm_in = 1'b0;

        // reset settings give unsaturated codes; the long hold-off falls here
        set_config(int'(aps_pkg::DEBOUNCE_RST), int'(aps_pkg::SPEED_K_RST));
        run_ticks(200, 5);

        set_config($urandom_range(40, 1), $urandom_range(65535, 1));
        run_ticks(80, 10);

        tick_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
